### src/feedback_delay_oversampled_core_assert.svh
// Assertion macros shared by the comb filter modules.
`ifndef FEEDBACK_DELAY_OVERSAMPLED_CORE_ASSERT_SVH
`define FEEDBACK_DELAY_OVERSAMPLED_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDO_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define FDO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

### src/fdo_pkg.sv
package fdo_pkg;

   localparam int DELAY_DEPTH = 8192;
   localparam int ADDR_W      = $clog2(DELAY_DEPTH);
   localparam int LEN_W       = ADDR_W + 1;
   localparam int SAMPLE_W    = 24;
   localparam int FB_W        = 16;
   localparam int OG_W        = 17;
   localparam int SHIFT_W     = 3;
   localparam int CNT_W       = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_W       = 17;
   localparam int SUM_W       = SAMPLE_W + 1;
   localparam int PROD_W      = SUM_W + OG_W;
   localparam int ACC_W       = PROD_W + 8;

   localparam logic signed [ACC_W-1:0] SAMPLE_MAX = ACC_W'(8388607);
   localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -ACC_W'(8388608);
   localparam logic signed [ACC_W-1:0] ACC_ONE    = ACC_W'(1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_LENGTH     = 2'd0,
      CSR_FEEDBACK_GAIN    = 2'd1,
      CSR_OUTPUT_GAIN      = 2'd2,
      CSR_OVERSAMPLE_SHIFT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [FB_W-1:0]    fb_gain;
      logic [OG_W-1:0]    out_gain;
      logic [SHIFT_W-1:0] shift;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic              last;
   } tick_type;

   typedef struct packed {
      logic                    valid;
      logic                    last;
      logic signed [SUM_W-1:0] sum;
   } mix_beat_type;

   function automatic sample_type sat_sample(input logic signed [ACC_W-1:0] v);
      sample_type r;
      if (v > SAMPLE_MAX) begin
         r = SAMPLE_MAX[SAMPLE_W-1:0];
      end else if (v < SAMPLE_MIN) begin
         r = SAMPLE_MIN[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

### src/fdo_channels.sv
interface fdo_req_if;
   logic                valid;
   logic                ready;
   fdo_pkg::sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface fdo_rsp_if;
   logic                valid;
   logic                ready;
   fdo_pkg::sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

### src/fdo_ring_ram.sv
module fdo_ring_ram #(
   parameter int DEPTH = 8192,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

### src/fdo_sequencer.sv
`include "feedback_delay_oversampled_core_assert.svh"

module fdo_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   fdo_req_if.sink                     req_ch,
   input  fdo_pkg::cfg_type            cfg,
   input  logic                        mix_done,
   output fdo_pkg::tick_type           issue_ff,
   output fdo_pkg::sample_type         x_ff,
   output logic                        rd_en,
   output logic [fdo_pkg::ADDR_W-1:0]  rd_addr
);
   import fdo_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] ptr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [ADDR_W-1:0] ptr_start;
   logic [ADDR_W-1:0] ptr_in;
   logic [CNT_W-1:0]  cnt_max;
   logic              last_tick;

   always_comb begin
      ptr_start = (LEN_W'(ptr_ff) >= cfg.len) ? '0 : ptr_ff;
      ptr_in    = (LEN_W'(ptr_ff) + LEN_W'(1) >= cfg.len) ? '0 : ptr_ff + ADDR_W'(1);
      cnt_max   = ~({CNT_W{1'b1}} << cfg.shift);
      last_tick = (cnt_ff == cnt_max);
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rd_en        = (state_ff == ST_RUN);
   assign rd_addr      = ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ptr_ff         <= '0;
         cnt_ff         <= '0;
         issue_ff.valid <= 1'b0;
      end else begin
         issue_ff.valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  x_ff     <= req_ch.sample_in;
                  ptr_ff   <= ptr_start;
                  cnt_ff   <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               issue_ff.valid <= 1'b1;
               issue_ff.addr  <= ptr_ff;
               issue_ff.last  <= last_tick;
               ptr_ff         <= ptr_in;
               cnt_ff         <= cnt_ff + CNT_W'(1);
               if (last_tick) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (mix_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `FDO_ASSERT_IMPLY(a_ptr_in_range, clock, reset, state_ff == ST_RUN, LEN_W'(ptr_ff) < cfg.len)
   `FDO_ASSERT_NEXT(a_accept_runs, clock, reset, req_ch.valid && req_ch.ready, state_ff == ST_RUN)
endmodule

### src/fdo_update.sv
`include "feedback_delay_oversampled_core_assert.svh"

module fdo_update (
   input  logic                        clock,
   input  logic                        reset,
   input  fdo_pkg::tick_type           issue,
   input  fdo_pkg::sample_type         rd_data,
   input  fdo_pkg::sample_type         x,
   input  logic [fdo_pkg::FB_W-1:0]    fb_gain,
   output logic                        wr_en,
   output logic [fdo_pkg::ADDR_W-1:0]  wr_addr,
   output fdo_pkg::sample_type         wr_data,
   output fdo_pkg::mix_beat_type       beat_ff
);
   import fdo_pkg::*;

   localparam int FBP_W = SAMPLE_W + FB_W + 1;

   logic               fwd_valid_ff;
   logic [ADDR_W-1:0]  fwd_addr_ff;
   sample_type         fwd_data_ff;
   logic [LEN_W-1:0]   fill_ff;
   sample_type         d;
   logic signed [FBP_W-1:0] fb_prod;
   logic signed [FBP_W-1:0] fb_round;
   logic signed [SUM_W-1:0] fb_term;
   logic signed [SUM_W:0]   new_wide;
   sample_type         new_val;
   logic signed [SUM_W-1:0] sum;

   // Entries are written in a prefix that grows from address zero, so the
   // fill count tells which entries still hold their cleared value.
   always_comb begin
      priority if (fwd_valid_ff && (fwd_addr_ff == issue.addr)) begin
         d = fwd_data_ff;
      end else if (LEN_W'(issue.addr) < fill_ff) begin
         d = rd_data;
      end else begin
         d = '0;
      end
      fb_prod  = FBP_W'(d) * FBP_W'($signed({1'b0, fb_gain}));
      fb_round = fb_prod + FBP_W'(32768);
      fb_term  = SUM_W'(fb_round >>> 16);
      new_wide = (SUM_W + 1)'(x) + (SUM_W + 1)'(fb_term);
      new_val  = sat_sample(ACC_W'(new_wide));
      sum      = SUM_W'(x) + SUM_W'(d);
   end

   assign wr_en   = issue.valid;
   assign wr_addr = issue.addr;
   assign wr_data = new_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff  <= 1'b0;
         fill_ff       <= '0;
         beat_ff.valid <= 1'b0;
      end else begin
         fwd_valid_ff  <= issue.valid;
         fwd_addr_ff   <= issue.addr;
         fwd_data_ff   <= new_val;
         beat_ff.valid <= issue.valid;
         beat_ff.last  <= issue.last;
         beat_ff.sum   <= sum;
         if (issue.valid && (LEN_W'(issue.addr) == fill_ff)) begin
            fill_ff <= fill_ff + LEN_W'(1);
         end
      end
   end

   `FDO_ASSERT_IMPLY(a_fill_prefix, clock, reset, issue.valid, LEN_W'(issue.addr) <= fill_ff)
   `FDO_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= LEN_W'(DELAY_DEPTH))
endmodule

### src/fdo_mix.sv
`include "feedback_delay_oversampled_core_assert.svh"

module fdo_mix (
   input  logic                        clock,
   input  logic                        reset,
   input  fdo_pkg::mix_beat_type       beat,
   input  logic [fdo_pkg::OG_W-1:0]    out_gain,
   input  logic [fdo_pkg::SHIFT_W-1:0] shift,
   fdo_rsp_if.source                   rsp_ch,
   output logic                        done
);
   import fdo_pkg::*;

   logic                     prod_valid_ff;
   logic                     prod_last_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     fin_ff;
   logic                     out_valid_ff;
   sample_type               out_data_ff;
   logic signed [ACC_W-1:0]  acc_round;
   logic signed [ACC_W-1:0]  acc_scaled;
   sample_type               y;
   logic                     load;

   // Round half up, then divide by both the Q1.16 gain scale and the
   // oversample factor in one arithmetic shift.
   always_comb begin
      acc_round  = acc_ff + (ACC_ONE << (5'd15 + 5'(shift)));
      acc_scaled = acc_round >>> (5'd16 + 5'(shift));
      y          = sat_sample(acc_scaled);
      load       = fin_ff && (!out_valid_ff || rsp_ch.ready);
   end

   assign done              = load;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.sample_out = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
         fin_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= beat.valid;
         prod_last_ff  <= beat.last;
         prod_ff       <= PROD_W'(beat.sum) * PROD_W'($signed({1'b0, out_gain}));
         if (load) begin
            acc_ff       <= '0;
            fin_ff       <= 1'b0;
            out_valid_ff <= 1'b1;
            out_data_ff  <= y;
         end else begin
            if (rsp_ch.ready) begin
               out_valid_ff <= 1'b0;
            end
            if (prod_valid_ff) begin
               acc_ff <= acc_ff + ACC_W'(prod_ff);
               if (prod_last_ff) begin
                  fin_ff <= 1'b1;
               end
            end
         end
      end
   end

   `FDO_ASSERT_IMPLY(a_no_beat_while_pending, clock, reset, fin_ff, !prod_valid_ff)
   `FDO_ASSERT_NEXT(a_load_shows_result, clock, reset, load, rsp_ch.valid)
endmodule

### src/feedback_delay_oversampled_core.sv
// Channel   Direction  Payload                     Handshake
// req_ch    in         sample_in  (24-bit signed)  valid / ready
// rsp_ch    out        sample_out (24-bit signed)  valid / ready
// csr_*     in         csr_wdata  (17-bit)         csr_write_en, no back-pressure
//
// After acceptance each beat runs 2^oversample_shift ticks, one ring read-modify-write
// per cycle; the issue, beat, product and accumulator registers then drain, and once
// the result loads the sequencer returns to idle, in which the next beat is taken.
// The single-port-read ring memory sets the pace of one oversampled tick per cycle.
// Reset is synchronous; the ring needs no clearing pass since a fill count marks
// the entries that were never written, and these read as zero.
// A stalled result waits in the output register while the next beat is taken.

module feedback_delay_oversampled_core (
   input  logic                          clock,
   input  logic                          reset,
   fdo_req_if.sink                       req_ch,
   fdo_rsp_if.source                     rsp_ch,
   input  logic                          csr_write_en,
   input  logic [fdo_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fdo_pkg::CSR_W-1:0]     csr_wdata
);
   import fdo_pkg::*;

   // Control registers, reset to unity output gain and a one-tick delay.
   logic [LEN_W-1:0]   len_ff;
   logic [FB_W-1:0]    fb_ff;
   logic [OG_W-1:0]    og_ff;
   logic [SHIFT_W-1:0] shift_ff;
   cfg_type            cfg;

   tick_type           issue_ff;
   sample_type         x_ff;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   sample_type         rd_data;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   sample_type         wr_data;
   mix_beat_type       beat_ff;
   logic               mix_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= LEN_W'(1);
         fb_ff    <= '0;
         og_ff    <= OG_W'(65536);
         shift_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELAY_LENGTH:     len_ff   <= csr_wdata[LEN_W-1:0];
            CSR_FEEDBACK_GAIN:    fb_ff    <= csr_wdata[FB_W-1:0];
            CSR_OUTPUT_GAIN:      og_ff    <= csr_wdata[OG_W-1:0];
            CSR_OVERSAMPLE_SHIFT: shift_ff <= csr_wdata[SHIFT_W-1:0];
         endcase
      end
   end

   // A zero length behaves as one tick, and a length beyond the ring is
   // clamped to the ring depth.
   always_comb begin
      if (len_ff == '0) begin
         cfg.len = LEN_W'(1);
      end else if (len_ff > LEN_W'(DELAY_DEPTH)) begin
         cfg.len = LEN_W'(DELAY_DEPTH);
      end else begin
         cfg.len = len_ff;
      end
      cfg.fb_gain  = fb_ff;
      cfg.out_gain = og_ff;
      cfg.shift    = shift_ff;
   end

   // The sequencer walks the ring pointer, issuing one memory read per tick.
   fdo_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cfg      (cfg),
      .mix_done (mix_done),
      .issue_ff (issue_ff),
      .x_ff     (x_ff),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr)
   );

   fdo_ring_ram #(
      .DEPTH (DELAY_DEPTH),
      .WIDTH (SAMPLE_W)
   ) u_ring (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // The update stage writes the feedback value back in the cycle after the read.
   // With a one-tick delay the next read overlaps that write, so the update
   // stage forwards its last written value.
   fdo_update u_update (
      .clock   (clock),
      .reset   (reset),
      .issue   (issue_ff),
      .rd_data (rd_data),
      .x       (x_ff),
      .fb_gain (cfg.fb_gain),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .beat_ff (beat_ff)
   );

   // The mixer scales each tick, sums over the oversampled ticks and holds the
   // finished result for the response channel.
   fdo_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .beat     (beat_ff),
      .out_gain (cfg.out_gain),
      .shift    (cfg.shift),
      .rsp_ch   (rsp_ch),
      .done     (mix_done)
   );
endmodule

### verif/feedback_delay_oversampled_core_tb.sv
module feedback_delay_oversampled_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fdo_pkg::*;

   // A beat's worst case is 2^7 ticks plus the pipeline drain. On top of that
   // come a long sender gap and a receiver stall, so QUIET_LIMIT quiet cycles
   // can only mean that the block has hung.
   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = (1 << 7) + 12;
   localparam int RANDOM_BEATS  = 400;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   fdo_req_if req_ch ();
   fdo_rsp_if rsp_ch ();

   feedback_delay_oversampled_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Samples waiting to be sent, and the outputs that the accepted ones must produce.
   sample_type pending_samples[$];
   sample_type predicted_outputs[$];

   // The predictor keeps its own copy of the echo ring, the tap pointer and the
   // register file. Config only changes while the block is idle, so the copy is
   // updated at the moment the write is issued.
   sample_type          echo_ring [DELAY_DEPTH];
   int unsigned         tap_index;
   logic [LEN_W-1:0]    dly_len_reg;
   logic [FB_W-1:0]     fb_gain_reg;
   logic [OG_W-1:0]     out_gain_reg;
   logic [SHIFT_W-1:0]  shift_reg;

   int   error_count = 0;
   int   quiet_cycles = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   stall_reload = 0;
   logic [15:0] stall_pattern = '1;
   // When set, neither side idles, which gives stretches of back-to-back beats.
   logic steady_run = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void queue_sample(input sample_type s);
      pending_samples = {pending_samples, s};
   endfunction

   function automatic sample_type next_sample();
      sample_type s;
      s = pending_samples[0];
      pending_samples.delete(0);
      return s;
   endfunction

   function automatic void add_prediction(input sample_type s);
      predicted_outputs = {predicted_outputs, s};
   endfunction

   function automatic sample_type take_prediction();
      sample_type s;
      s = predicted_outputs[0];
      predicted_outputs.delete(0);
      return s;
   endfunction

   function automatic sample_type clip24(input longint v);
      sample_type r;
      if (v > 64'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -64'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // Runs all oversampled ticks of one input sample through the ring and returns
   // the averaged, gain-scaled mix of the sample and the delayed value.
   function automatic sample_type comb_output(input sample_type x_in);
      int unsigned span;
      int unsigned tick_total;
      int unsigned t;
      longint x;
      longint d;
      longint fb;
      longint acc;
      longint y;
      span = 32'(dly_len_reg);
      if (span == 0) begin
         span = 1;
      end
      if (span > DELAY_DEPTH) begin
         span = DELAY_DEPTH;
      end
      tick_total = 1 << shift_reg;
      x = longint'(x_in);
      acc = 0;
      // A shortened delay can leave the pointer past the new end of the ring.
      if (tap_index >= span) begin
         tap_index = 0;
      end
      for (t = 0; t < tick_total; t++) begin
         d = longint'(echo_ring[tap_index]);
         // The feedback product rounds half up; >>> on a signed value floors.
         fb = (longint'(fb_gain_reg) * d + 64'sd32768) >>> 16;
         echo_ring[tap_index] = clip24(x + fb);
         tap_index++;
         if (tap_index >= span) begin
            tap_index = 0;
         end
         acc += (x + d) * longint'(out_gain_reg);
      end
      y = (acc + (longint'(1) << (15 + shift_reg))) >>> (16 + shift_reg);
      return clip24(y);
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      case ($urandom_range(0, 9))
         0: s = 24'sh7FFFFF;
         1: s = 24'sh800000;
         2: s = sample_type'($urandom_range(0, 64)) - 24'sd32;
         default: s = sample_type'($urandom());
      endcase
      return s;
   endfunction

   // Register writes happen only while the block is idle.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         CSR_DELAY_LENGTH:     dly_len_reg  = value[LEN_W-1:0];
         CSR_FEEDBACK_GAIN:    fb_gain_reg  = value[FB_W-1:0];
         CSR_OUTPUT_GAIN:      out_gain_reg = value[OG_W-1:0];
         CSR_OVERSAMPLE_SHIFT: shift_reg    = value[SHIFT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_W-1:0] len, input logic [CSR_W-1:0] fb,
                            input logic [CSR_W-1:0] og, input logic [CSR_W-1:0] sh);
      write_csr(CSR_DELAY_LENGTH, len);
      write_csr(CSR_FEEDBACK_GAIN, fb);
      write_csr(CSR_OUTPUT_GAIN, og);
      write_csr(CSR_OVERSAMPLE_SHIFT, sh);
      @(negedge clock);
   endtask

   // Polls on the falling edge so that it never races the clocked blocks. Every
   // beat yields exactly one output, so an empty prediction store means idle.
   task automatic wait_for_idle();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_ch.valid || predicted_outputs.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Stimulus: directed phases first, then random phases under random settings.
   initial begin
      int beats_sent;
      int n;
      int hold_point;
      logic [CSR_W-1:0] len_val;
      logic [CSR_W-1:0] fb_val;
      logic [CSR_W-1:0] og_val;
      logic [CSR_W-1:0] sh_val;
      bit first_phase;

      reset        = 1'b1;
      csr_write_en = 1'b0;
      csr_index    = CSR_DELAY_LENGTH;
      csr_wdata    = '0;
      req_ch.valid     = 1'b0;
      req_ch.sample_in = '0;
      rsp_ch.ready     = 1'b0;
      foreach (echo_ring[i]) begin
         echo_ring[i] = '0;
      end
      tap_index    = 0;
      dly_len_reg  = LEN_W'(1);
      fb_gain_reg  = '0;
      out_gain_reg = 17'd65536;
      shift_reg    = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: a one-tick delay with no feedback and unity gain.
      queue_sample(24'sh7FFFFF);
      queue_sample(24'sh800000);
      queue_sample(24'sh000000);
      queue_sample(-24'sd1);
      queue_sample(24'sd1);
      queue_sample(24'sh555555);
      queue_sample(24'shAAAAAA);

      // A zero delay length acts as one; full feedback and an output gain near
      // two drive the mix into saturation at the largest oversample factor.
      wait_for_idle();
      configure(17'd0, 17'd65535, 17'd131071, 17'd7);
      queue_sample(24'sh7FFFFF);
      queue_sample(24'sh7FFFFF);
      queue_sample(24'sh800000);
      queue_sample(24'sh800000);
      queue_sample(24'sh000000);

      // A delay length above the ring depth is clamped to the depth.
      wait_for_idle();
      configure(17'd16383, 17'd58982, 17'd26214, 17'd3);
      repeat (3) queue_sample(random_sample());
      queue_sample(24'sh7FFFFF);

      // Seven beats of two ticks each leave the pointer at four in a ring of five.
      wait_for_idle();
      configure(17'd5, 17'd32768, 17'd65536, 17'd1);
      repeat (7) queue_sample(random_sample());

      // Shrinking the ring to three puts the pointer past its end; it must wrap.
      wait_for_idle();
      configure(17'd3, 17'd32768, 17'd65536, 17'd0);
      repeat (3) queue_sample(random_sample());

      beats_sent = 0;
      first_phase = 1'b1;
      while (beats_sent < RANDOM_BEATS) begin
         wait_for_idle();
         steady_run = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 7))
            0: len_val = 17'd0;
            1: len_val = 17'd1;
            2: len_val = CSR_W'($urandom_range(2, 16));
            3: len_val = CSR_W'($urandom_range(17, 300));
            4: len_val = 17'd8192;
            5: len_val = CSR_W'($urandom_range(8193, 16383));
            6: len_val = CSR_W'($urandom_range(1, 8192));
            default: len_val = CSR_W'($urandom_range(0, 131071));
         endcase
         case ($urandom_range(0, 5))
            0: fb_val = 17'd0;
            1: fb_val = 17'd65535;
            2: fb_val = 17'd58982;
            3: fb_val = CSR_W'($urandom_range(0, 131071));
            default: fb_val = CSR_W'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 5))
            0: og_val = 17'd0;
            1: og_val = 17'd26214;
            2: og_val = 17'd65536;
            3: og_val = 17'd131071;
            default: og_val = CSR_W'($urandom_range(0, 131071));
         endcase
         if ($urandom_range(0, 4) == 0) begin
            sh_val = CSR_W'($urandom_range(0, 131071));
         end else begin
            sh_val = CSR_W'($urandom_range(0, 7));
         end
         configure(len_val, fb_val, og_val, sh_val);

         // Now and then the sender stops halfway and lets every output drain.
         n = $urandom_range(20, 60);
         hold_point = (first_phase || $urandom_range(0, 3) == 0) ? n / 2 : n;
         first_phase = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (i == hold_point) begin
               wait_for_idle();
            end
            queue_sample(random_sample());
         end
         beats_sent += n;
      end

      wait_for_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Sender: offers queued samples in bursts of random length with random gaps.
   // The expected output is worked out at the edge where a beat is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.sample_in <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            add_prediction(comb_output(req_ch.sample_in));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_ch.valid     <= 1'b1;
               req_ch.sample_in <= next_sample();
               if (burst_left > 0) begin
                  burst_left--;
               end
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  if (steady_run) begin
                     gap_left = 0;
                  end else begin
                     // Gap lengths span the whole beat time, so the next beat
                     // lands on every phase of the tick loop.
                     case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: gap_left = 0;
                        6, 7, 8: gap_left = $urandom_range(1, 8);
                        default: gap_left = $urandom_range(9, 140);
                     endcase
                  end
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready follows a rotating 16-bit pattern that is reloaded whenever its
   // reload counter runs out, from all ones through random mixes to a mostly stalled pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stall_reload == 0) begin
            stall_reload = 48;
            if (steady_run) begin
               stall_pattern = '1;
            end else begin
               case ($urandom_range(0, 3))
                  0: stall_pattern = '1;
                  1: stall_pattern = 16'($urandom());
                  2: stall_pattern = 16'($urandom() & $urandom());
                  default: stall_pattern = 16'h0001;
               endcase
            end
         end
         stall_reload--;
         rsp_ch.ready <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   // Output check: each accepted output beat is compared with the oldest prediction.
   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (predicted_outputs.size() == 0) begin
            $display("%0t: output beat with none expected, actual %0d",
                     $time, rsp_ch.sample_out);
            error_count++;
         end else begin
            want = take_prediction();
            if (rsp_ch.sample_out !== want) begin
               $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                        $time, want, rsp_ch.sample_out);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too many cycles without any beat or register write means a hang.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                   || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d outputs outstanding",
                  $time, QUIET_LIMIT, predicted_outputs.size());
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
